>>> src/sdd_pkg.sv
// ----------------------------------------------------------------------------
// sdd_pkg
// Shared types and constants for the shuffled deck dealer.
// ----------------------------------------------------------------------------
package sdd_pkg;

  // Default deck capacity (entries in the deck memory)
  localparam int DECK_CAPACITY = 128;

  // Galois LFSR feedback mask
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  // Register reset values
  localparam logic [7:0]  COUNT_RESET = 8'd37;
  localparam logic [31:0] SEED_RESET  = 32'd1;

  // APB register map: registers lie at byte addresses 0 and 4, selected by paddr[2]
  localparam int   APB_ADDR_W      = 3;
  localparam logic REG_DECK_COUNT  = 1'b0;
  localparam logic REG_RANDOM_SEED = 1'b1;

  // Stream data widths
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 8;
  localparam int INDEX_W  = 7;

  // Controller states
  typedef enum logic [3:0] {
    ST_FILL,      // identity sweep of the deck memory
    ST_IDLE,      // waiting for a draw
    ST_SH_START,  // step LFSR, start remainder, read deck[i]
    ST_SH_CAPI,   // capture deck[i]
    ST_SH_DIV,    // wait for remainder, read deck[j]
    ST_SH_WRI,    // deck[i] <= deck[j]
    ST_SH_WRJ,    // deck[j] <= old deck[i]
    ST_DEAL_RD,   // read deck at current position
    ST_DEAL_CAP,  // capture dealt entry, decide on restart
    ST_OUT        // hand result to the output register
  } sdd_state_e;

endpackage

>>> src/sdd_ram.sv
// ----------------------------------------------------------------------------
// sdd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sdd_ram #(
  parameter int Width = 8,
  parameter int Depth = 128,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/sdd_rem_unit.sv
// ----------------------------------------------------------------------------
// sdd_rem_unit
// Iterative remainder of a 32-bit value by the deck count, two bits a cycle.
// ----------------------------------------------------------------------------
module sdd_rem_unit #(
  parameter int CountW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       dividend_i,
  input  logic [CountW-1:0] divisor_i,
  output logic              done_o,
  output logic [CountW-1:0] rem_o
);

  localparam int BitsPerCycle = 2;
  localparam int Steps        = 32 / BitsPerCycle;
  localparam int StepW        = $clog2(Steps);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [31:0]       quo_q, quo_d;
  logic [CountW-1:0] rem_q, rem_d;

  // restoring remainder steps for this cycle
  logic [31:0]       sh;
  logic [CountW-1:0] r;
  logic [CountW:0]   ext;

  always_comb begin
    sh  = quo_q;
    r   = rem_q;
    ext = '0;
    for (int k = 0; k < BitsPerCycle; k++) begin
      ext = {r, sh[31]};
      sh  = {sh[30:0], 1'b0};
      if (ext >= {1'b0, divisor_i}) begin
        ext = ext - {1'b0, divisor_i};
      end
      r = ext[CountW-1:0];
    end
  end

  // sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d  = sh;
      rem_d  = r;
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> src/shuffled_deck_dealer_core.sv
// ----------------------------------------------------------------------------
// shuffled_deck_dealer_core
// Shuffle-bag dealer: deals deck entry indices in LFSR-shuffled order.
// ----------------------------------------------------------------------------
// One draw item (s_tdata bit 0 set) returns one result: the entry index and,
// on m_tlast, a flag that the draw used up the deck and a reshuffle was done.
// A draw with the deck ready goes through DEAL_RD, DEAL_CAP and OUT to the
// output register, and the block is back in idle as the result is loaded.
// A shuffle pass runs before the first draw and on the draw that empties the
// deck; it makes one swap per used entry: the LFSR step, 16 two-bits-per-cycle
// remainder steps and the done cycle, plus the two writes on the
// single-write-port deck memory. After reset and after every deck_count write
// the deck memory is swept back to identity, one entry per cycle, while no
// draw is accepted; APB writes are taken at any time. The block handles one
// draw at a time and accepts the next one while a result still waits on the
// master side.
// ----------------------------------------------------------------------------
module shuffled_deck_dealer_core
  import sdd_pkg::*;
#(
  parameter int DeckCapacity = DECK_CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // draw requests
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // [0] draw, [7:1] zero
  // dealt entries
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [6:0] entry_index, [7] zero
  output logic                  m_tlast,   // deck_restarted
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int AW = (DeckCapacity > 1) ? $clog2(DeckCapacity) : 1;
  localparam int CW = $clog2(DeckCapacity + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  deck_count_q;
  logic [31:0] random_seed_q;
  logic        cfg_wr;
  logic        cfg_count_wr;
  logic        cfg_seed_wr;

  assign pready       = 1'b1;
  assign cfg_wr       = psel & penable & pwrite;
  assign cfg_count_wr = cfg_wr & (paddr[2] == REG_DECK_COUNT);
  assign cfg_seed_wr  = cfg_wr & (paddr[2] == REG_RANDOM_SEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_count_q  <= COUNT_RESET;
      random_seed_q <= SEED_RESET;
    end else begin
      if (cfg_count_wr) begin
        deck_count_q <= pwdata[7:0];
      end
      if (cfg_seed_wr) begin
        random_seed_q <= pwdata;
      end
    end
  end

  // register read-back
  always_comb begin
    case (paddr[2])
      REG_DECK_COUNT:  prdata = {24'd0, deck_count_q};
      REG_RANDOM_SEED: prdata = random_seed_q;
      default:         prdata = '0;
    endcase
  end

  // count in use: zero acts as one, clamp at capacity
  logic [CW-1:0] used_cnt;

  always_comb begin
    if (deck_count_q == 8'd0) begin
      used_cnt = CW'(1);
    end else if (32'(deck_count_q) > 32'(DeckCapacity)) begin
      used_cnt = CW'(DeckCapacity);
    end else begin
      used_cnt = CW'(deck_count_q);
    end
  end

  // --------------------------------------------------------------------------
  // Deck memory and remainder unit
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_rdata;

  sdd_ram #(
    .Width (AW),
    .Depth (DeckCapacity)
  ) u_deck_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic          rem_start;
  logic [31:0]   lfsr_next;
  logic          rem_done;
  logic [CW-1:0] rem_val;

  sdd_rem_unit #(
    .CountW (CW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (lfsr_next),
    .divisor_i  (used_cnt),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  sdd_state_e    state_q, state_d;
  logic [31:0]   lfsr_q, lfsr_d;
  logic [CW-1:0] pos_q, pos_d;        // next deal position
  logic          pending_q, pending_d; // shuffle before next deal
  logic [CW-1:0] idx_i_q, idx_i_d;    // swap position i
  logic [AW-1:0] fill_q, fill_d;
  logic          restart_q, restart_d;
  logic          out_valid_q, out_valid_d;
  logic [AW-1:0] di_q, di_d;          // old deck[i]
  logic [AW-1:0] j_q, j_d;            // swap partner
  logic [AW-1:0] dealt_q, dealt_d;
  logic [INDEX_W-1:0] out_idx_q, out_idx_d;
  logic          out_last_q, out_last_d;
  logic [CW-1:0] pos_sel;
  logic [CW-1:0] i_inc;

  // one Galois LFSR step
  assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? LFSR_MASK : 32'd0);
  assign pos_sel   = (pos_q >= used_cnt) ? '0 : pos_q;
  assign i_inc     = idx_i_q + CW'(1);

  always_comb begin
    state_d     = state_q;
    lfsr_d      = lfsr_q;
    pos_d       = pos_q;
    pending_d   = pending_q;
    idx_i_d     = idx_i_q;
    fill_d      = fill_q;
    restart_d   = restart_q;
    out_valid_d = out_valid_q;
    di_d        = di_q;
    j_d         = j_q;
    dealt_d     = dealt_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_i_q[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_i_q[AW-1:0];
    rem_start   = 1'b0;
    s_tready    = 1'b0;

    // output register drains independently
    if (out_valid_q && m_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_q;
        ram_wdata = fill_q;
        fill_d    = fill_q + AW'(1);
        if (fill_q == AW'(DeckCapacity - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tdata[0]) begin
          restart_d = 1'b0;
          if (pending_q) begin
            idx_i_d = '0;
            state_d = ST_SH_START;
          end else begin
            state_d = ST_DEAL_RD;
          end
        end
      end
      ST_SH_START: begin
        lfsr_d    = lfsr_next;
        rem_start = 1'b1;
        state_d   = ST_SH_CAPI;
      end
      ST_SH_CAPI: begin
        di_d    = ram_rdata;
        state_d = ST_SH_DIV;
      end
      ST_SH_DIV: begin
        ram_raddr = rem_val[AW-1:0];
        if (rem_done) begin
          j_d     = rem_val[AW-1:0];
          state_d = ST_SH_WRI;
        end
      end
      ST_SH_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = idx_i_q[AW-1:0];
        ram_wdata = ram_rdata;
        state_d   = ST_SH_WRJ;
      end
      ST_SH_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = di_q;
        idx_i_d   = i_inc;
        if (i_inc >= used_cnt) begin
          pos_d     = '0;
          pending_d = 1'b0;
          state_d   = restart_q ? ST_OUT : ST_DEAL_RD;
        end else begin
          state_d = ST_SH_START;
        end
      end
      ST_DEAL_RD: begin
        ram_raddr = pos_sel[AW-1:0];
        pos_d     = pos_sel + CW'(1);
        state_d   = ST_DEAL_CAP;
      end
      ST_DEAL_CAP: begin
        dealt_d = ram_rdata;
        if (pos_q >= used_cnt) begin
          restart_d = 1'b1;
          idx_i_d   = '0;
          state_d   = ST_SH_START;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_tready) begin
          out_valid_d = 1'b1;
          out_idx_d   = INDEX_W'(dealt_q);
          out_last_d  = restart_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // configuration writes take priority
    if (cfg_count_wr) begin
      state_d   = ST_FILL;
      fill_d    = '0;
      pos_d     = '0;
      pending_d = 1'b1;
    end
    if (cfg_seed_wr) begin
      lfsr_d = (pwdata == 32'd0) ? 32'd1 : pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      lfsr_q      <= SEED_RESET;
      pos_q       <= '0;
      pending_q   <= 1'b1;
      idx_i_q     <= '0;
      fill_q      <= '0;
      restart_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      pos_q       <= pos_d;
      pending_q   <= pending_d;
      idx_i_q     <= idx_i_d;
      fill_q      <= fill_d;
      restart_q   <= restart_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    di_q       <= di_d;
    j_q        <= j_d;
    dealt_q    <= dealt_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {1'b0, out_idx_q};
  assign m_tlast  = out_last_q;

endmodule

>>> src/sdd_checker.sv
// ----------------------------------------------------------------------------
// sdd_checker
// Port-level assertions for the shuffled deck dealer, bound to the top level.
// ----------------------------------------------------------------------------
module sdd_checker
  import sdd_pkg::*;
#(
  parameter int DeckCapacity = DECK_CAPACITY
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [S_DATA_W-1:0]   s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata,
  input logic                  m_tlast,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic                  pready
);

  // shadow of deck_count, from APB write transactions
  logic [7:0]  count_q;
  logic [31:0] used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DECK_COUNT)) begin
      count_q <= pwdata[7:0];
    end
  end

  always_comb begin
    if (count_q == 8'd0) begin
      used = 32'd1;
    end else if (32'(count_q) > 32'(DeckCapacity)) begin
      used = 32'(DeckCapacity);
    end else begin
      used = 32'(count_q);
    end
  end

  // APB never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // a draw transaction keeps the block busy for at least the next cycle
  a_busy_after_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready && s_tdata[0]) |=> !s_tready)
    else $error("draw accepted back to back");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

  // dealt index lies inside the deck in use
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (32'(m_tdata[6:0]) < used))
    else $error("dealt index out of range");

  // a one-entry deck always deals entry zero and restarts
  a_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && (used == 32'd1)) |-> (m_tlast && (m_tdata[6:0] == 7'd0)))
    else $error("one-entry deck dealt wrong result");

endmodule

bind shuffled_deck_dealer_core sdd_checker #(
  .DeckCapacity (DeckCapacity)
) u_sdd_checker (.*);
